### hdl/dmct_pkg.sv
`default_nettype none

package dmct_pkg;

    // field widths fixed by the item format
    localparam int REQ_W      = 2;
    localparam int COORD_W    = 32;
    localparam int OUTCOME_W  = 3;
    localparam int SLOT_IDX_W = 10;
    localparam int COUNT_W    = 11;

    // default grid side, a power of two
    localparam int GRID_SIDE_DEFAULT = 32;

    typedef logic [REQ_W-1:0]         req_type_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [OUTCOME_W-1:0]     outcome_t;
    typedef logic [SLOT_IDX_W-1:0]    slot_idx_t;
    typedef logic [COUNT_W-1:0]       count_t;

    // request codes
    localparam req_type_t REQ_OBTAIN   = 2'd0;
    localparam req_type_t REQ_DROP     = 2'd1;
    localparam req_type_t REQ_DROP_ALL = 2'd2;

    // outcome codes
    localparam outcome_t OUT_LAST_HIT    = 3'd0;
    localparam outcome_t OUT_SLOT_HIT    = 3'd1;
    localparam outcome_t OUT_FILLED      = 3'd2;
    localparam outcome_t OUT_REPLACED    = 3'd3;
    localparam outcome_t OUT_DROPPED     = 3'd4;
    localparam outcome_t OUT_IGNORED     = 3'd5;
    localparam outcome_t OUT_ALL_DROPPED = 3'd6;

    // one slot of the tag memory
    typedef struct packed {
        logic   valid;
        coord_t x;
        coord_t z;
    } slot_entry_t;

endpackage

`default_nettype wire

### hdl/dmct_req_if.sv
`default_nettype none

interface dmct_req_if;
    import dmct_pkg::*;

    logic      valid;
    logic      ready;
    req_type_t req_type;
    coord_t    col_x;
    coord_t    col_z;

    modport source (output valid, output req_type, output col_x, output col_z, input ready);
    modport sink (input valid, input req_type, input col_x, input col_z, output ready);
endinterface

`default_nettype wire

### hdl/dmct_rsp_if.sv
`default_nettype none

interface dmct_rsp_if;
    import dmct_pkg::*;

    logic      valid;
    logic      ready;
    outcome_t  outcome;
    slot_idx_t slot_index;
    coord_t    evicted_x;
    coord_t    evicted_z;
    count_t    resident_count;

    modport source (
        output valid, output outcome, output slot_index, output evicted_x,
        output evicted_z, output resident_count, input ready
    );
    modport sink (
        input valid, input outcome, input slot_index, input evicted_x,
        input evicted_z, input resident_count, output ready
    );
endinterface

`default_nettype wire

### hdl/dmct_slot_ram.sv
`default_nettype none

module dmct_slot_ram #(
    parameter int IDX_W = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rd_en,
    input  wire logic [IDX_W-1:0]      rd_addr,
    output dmct_pkg::slot_entry_t      rd_data,
    input  wire logic                  wr_en,
    input  wire logic [IDX_W-1:0]      wr_addr,
    input  wire dmct_pkg::slot_entry_t wr_data
);
    import dmct_pkg::*;

    localparam int DEPTH = 1 << IDX_W;

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/dmct_ctrl.sv
`default_nettype none

module dmct_ctrl #(
    parameter int GRID_SIDE = dmct_pkg::GRID_SIDE_DEFAULT,
    localparam int IDX_W = 2 * $clog2(GRID_SIDE)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dmct_req_if.sink                   req,
    dmct_rsp_if.source                 rsp,
    output logic                       rd_en,
    output logic [IDX_W-1:0]           rd_addr,
    input  wire dmct_pkg::slot_entry_t rd_data,
    output logic                       wr_en,
    output logic [IDX_W-1:0]           wr_addr,
    output dmct_pkg::slot_entry_t      wr_data
);
    import dmct_pkg::*;

    localparam int SIDE_W     = $clog2(GRID_SIDE);
    localparam int SLOT_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam logic [CNT_W-1:0] SLOT_COUNT_C = CNT_W'(SLOT_COUNT);
    localparam logic [CNT_W-1:0] CNT_ONE      = CNT_W'(1);
    localparam logic [IDX_W-1:0] ADDR_ONE     = IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_CLEAR  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clear_addr_reg;

    // request held during lookup
    req_type_t        req_type_reg;
    coord_t           x_reg, z_reg;
    logic [IDX_W-1:0] slot_reg;

    // last-hit register and occupancy
    coord_t           last_x_reg, last_x_next;
    coord_t           last_z_reg, last_z_next;
    logic             last_valid_reg, last_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // output register
    logic             out_valid_reg;
    outcome_t         outcome_reg, outcome_next;
    slot_idx_t        slot_index_reg, slot_index_next;
    coord_t           evicted_x_reg, evicted_x_next;
    coord_t           evicted_z_reg, evicted_z_next;
    count_t           resident_count_reg, resident_count_next;

    logic             req_accept;
    logic             out_free;
    logic             step;
    logic             hit_last;
    logic             tag_match;
    logic             wb_en;
    slot_entry_t      wb_entry;
    logic             go_clear;
    logic [IDX_W-1:0] slot_res;
    logic [IDX_W+SLOT_IDX_W-1:0] slot_wide;
    logic [CNT_W+COUNT_W-1:0]    count_wide;

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_accept = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign step       = (state_reg == ST_LOOKUP) && out_free;

    // slot = x low bits + GRID_SIDE * z low bits
    assign rd_en   = req_accept;
    assign rd_addr = {req.col_z[SIDE_W-1:0], req.col_x[SIDE_W-1:0]};

    assign hit_last  = last_valid_reg && (last_x_reg == x_reg) && (last_z_reg == z_reg);
    assign tag_match = rd_data.valid && (rd_data.x == x_reg) && (rd_data.z == z_reg);

    always_comb
    begin
        last_x_next     = last_x_reg;
        last_z_next     = last_z_reg;
        last_valid_next = last_valid_reg;
        count_next      = count_reg;
        outcome_next    = OUT_IGNORED;
        slot_res        = slot_reg;
        evicted_x_next  = '0;
        evicted_z_next  = '0;
        wb_en           = 1'b0;
        wb_entry        = '{valid: 1'b1, x: x_reg, z: z_reg};
        go_clear        = 1'b0;
        case (req_type_reg)
            REQ_OBTAIN:
            begin
                if (hit_last)
                begin
                    outcome_next = OUT_LAST_HIT;
                end
                else if (tag_match)
                begin
                    outcome_next = OUT_SLOT_HIT;
                end
                else
                begin
                    wb_en = 1'b1;
                    if (rd_data.valid)
                    begin
                        outcome_next   = OUT_REPLACED;
                        evicted_x_next = rd_data.x;
                        evicted_z_next = rd_data.z;
                    end
                    else
                    begin
                        outcome_next = OUT_FILLED;
                        if (count_reg < SLOT_COUNT_C)
                        begin
                            count_next = count_reg + CNT_ONE;
                        end
                    end
                end
                last_x_next     = x_reg;
                last_z_next     = z_reg;
                last_valid_next = 1'b1;
            end
            REQ_DROP:
            begin
                if (tag_match)
                begin
                    wb_en    = 1'b1;
                    wb_entry = '{valid: 1'b0, x: rd_data.x, z: rd_data.z};
                    if (hit_last)
                    begin
                        last_valid_next = 1'b0;
                        last_x_next     = '0;
                        last_z_next     = '0;
                    end
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_ONE;
                    end
                    outcome_next = OUT_DROPPED;
                end
            end
            REQ_DROP_ALL:
            begin
                count_next      = '0;
                last_valid_next = 1'b0;
                last_x_next     = '0;
                last_z_next     = '0;
                slot_res        = '0;
                outcome_next    = OUT_ALL_DROPPED;
                go_clear        = 1'b1;
            end
            default:
            begin
                outcome_next = OUT_IGNORED;
            end
        endcase
    end

    // fit internal widths onto the fixed output fields
    assign slot_wide           = {{SLOT_IDX_W{1'b0}}, slot_res};
    assign slot_index_next     = slot_wide[SLOT_IDX_W-1:0];
    assign count_wide          = {{COUNT_W{1'b0}}, count_next};
    assign resident_count_next = count_wide[COUNT_W-1:0];

    // write port: clearing sweep or lookup write-back
    assign wr_en   = (state_reg == ST_CLEAR) || (step && wb_en);
    assign wr_addr = (state_reg == ST_CLEAR) ? clear_addr_reg : slot_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? slot_entry_t'('0) : wb_entry;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (step)
                begin
                    state_next = go_clear ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (clear_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            last_x_reg     <= '0;
            last_z_reg     <= '0;
            last_valid_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clear_addr_reg <= clear_addr_reg + ADDR_ONE;
            end
            if (step)
            begin
                last_x_reg     <= last_x_next;
                last_z_reg     <= last_z_next;
                last_valid_reg <= last_valid_next;
                count_reg      <= count_next;
                out_valid_reg  <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_type_reg <= req.req_type;
            x_reg        <= req.col_x;
            z_reg        <= req.col_z;
            slot_reg     <= rd_addr;
        end
        if (step)
        begin
            outcome_reg        <= outcome_next;
            slot_index_reg     <= slot_index_next;
            evicted_x_reg      <= evicted_x_next;
            evicted_z_reg      <= evicted_z_next;
            resident_count_reg <= resident_count_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.outcome        = outcome_reg;
    assign rsp.slot_index     = slot_index_reg;
    assign rsp.evicted_x      = evicted_x_reg;
    assign rsp.evicted_z      = evicted_z_reg;
    assign rsp.resident_count = resident_count_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOT_COUNT_C)
        else $error("resident count above slot count");

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> (state_reg == ST_LOOKUP))
        else $error("accepted item not followed by lookup");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg != ST_IDLE))
        else $error("memory written while idle");

    a_last_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !last_valid_reg |-> (last_x_reg == '0) && (last_z_reg == '0))
        else $error("invalid last-hit register holds coordinates");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CLEAR) && (clear_addr_reg == '1)) |=> (count_reg == '0))
        else $error("count not zero after clearing sweep");
`endif

endmodule

`default_nettype wire

### hdl/direct_mapped_column_tag_store.sv
`default_nettype none

// direct-mapped tag store for 2-D column coordinates. each column (x, z)
// owns one slot, {z low bits, x low bits}, in a single-port-read,
// single-port-write memory of GRID_SIDE*GRID_SIDE entries; each entry holds
// a valid bit and the full 32-bit x and z. for an obtain or drop item the
// slot is read on the accepting edge, and the compare, the write-back and
// the result register load happen on the edge that ends the lookup; a new
// item is taken only once the last one has left the lookup. the result
// register holds one finished item, and the next item may be accepted
// while it waits; a lookup stalls only when that register is still full.
// a drop-all item answers in the same way, then the block sweeps the
// memory to clear the valid bits, one slot per cycle over all
// GRID_SIDE*GRID_SIDE slots, during which no item is accepted. the same
// sweep runs right after reset. GRID_SIDE must be a power of two; slot_index
// carries the low 10 bits of the slot and resident_count the low 11 bits of the count

module direct_mapped_column_tag_store #(
    parameter int GRID_SIDE = dmct_pkg::GRID_SIDE_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dmct_req_if.sink   req,
    dmct_rsp_if.source rsp
);
    import dmct_pkg::*;

    localparam int IDX_W = 2 * $clog2(GRID_SIDE);

    // memory ports between control and tag memory
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    slot_entry_t      rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_entry_t      wr_data;

    // lookup, last-hit register, occupancy count and result register
    dmct_ctrl #(
        .GRID_SIDE (GRID_SIDE)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // tag memory with valid bit, registered read
    dmct_slot_ram #(
        .IDX_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire

### tb/tb_direct_mapped_column_tag_store.sv
`timescale 1ns / 1ps

module tb_direct_mapped_column_tag_store;
    import dmct_pkg::*;

    // geometry at the default grid side
    localparam int GRID  = GRID_SIDE_DEFAULT;
    localparam int SLOTS = GRID * GRID;
    localparam int unsigned LOW_BITS_MASK = GRID - 1;

    // request code the block does not define, answered as a drop ignored
    localparam req_type_t REQ_UNUSED = 2'd3;

    // random part and coordinate pool sizes
    localparam int RANDOM_ITEMS = 830;
    localparam int POOL_SIZE    = 64;

    // drain after the last result: a trailing drop-all sweep plus a margin
    localparam int DRAIN_CYCLES = SLOTS + 64;

    // generous bound: ~850 items at a heavy receiver stall, a dozen or so
    // drop-all sweeps, the sweep after reset, all taken several times over
    localparam int CYCLE_LIMIT = 400000;

    // one result item as the block reports it
    typedef struct {
        outcome_t  outcome;
        slot_idx_t slot_index;
        coord_t    evicted_x;
        coord_t    evicted_z;
        count_t    resident_count;
    } column_result_t;

    // home slot of a column: low bits of x plus GRID times low bits of z
    function automatic int unsigned home_slot(coord_t x, coord_t z);
        bit [31:0] ux;
        bit [31:0] uz;
        ux = x;
        uz = z;
        return ((ux & LOW_BITS_MASK) + GRID * (uz & LOW_BITS_MASK)) % SLOTS;
    endfunction

    // shadow copy of the tag store; predicts one result per accepted item
    // and checks the block's results against them in order
    class tag_store_shadow;
        bit [31:0]      held_x [SLOTS];
        bit [31:0]      held_z [SLOTS];
        bit             held_valid [SLOTS];
        bit [31:0]      recent_x;
        bit [31:0]      recent_z;
        bit             recent_valid;
        int unsigned    occupancy;
        column_result_t expected_results [$];
        int             errors;

        function new();
            foreach (held_valid[i])
            begin
                held_valid[i] = 1'b0;
                held_x[i]     = '0;
                held_z[i]     = '0;
            end
            recent_x     = '0;
            recent_z     = '0;
            recent_valid = 1'b0;
            occupancy    = 0;
            errors       = 0;
        endfunction

        // advance the shadow by one accepted request and queue its result
        function void note_request(req_type_t code, coord_t x, coord_t z);
            column_result_t want;
            int unsigned    s;
            bit             slot_match;
            bit             recent_match;
            s            = home_slot(x, z);
            slot_match   = held_valid[s] && held_x[s] == x && held_z[s] == z;
            recent_match = recent_valid && recent_x == x && recent_z == z;
            want.outcome   = OUT_IGNORED;
            want.evicted_x = '0;
            want.evicted_z = '0;
            case (code)
                REQ_OBTAIN:
                begin
                    if (recent_match)
                        want.outcome = OUT_LAST_HIT;
                    else if (slot_match)
                        want.outcome = OUT_SLOT_HIT;
                    else
                    begin
                        if (held_valid[s])
                        begin
                            want.outcome   = OUT_REPLACED;
                            want.evicted_x = held_x[s];
                            want.evicted_z = held_z[s];
                        end
                        else
                        begin
                            want.outcome = OUT_FILLED;
                            if (occupancy < SLOTS)
                                occupancy++;
                        end
                        held_x[s]     = x;
                        held_z[s]     = z;
                        held_valid[s] = 1'b1;
                    end
                    recent_x     = x;
                    recent_z     = z;
                    recent_valid = 1'b1;
                end
                REQ_DROP:
                begin
                    if (slot_match)
                    begin
                        if (recent_match)
                        begin
                            recent_valid = 1'b0;
                            recent_x     = '0;
                            recent_z     = '0;
                        end
                        held_valid[s] = 1'b0;
                        if (occupancy > 0)
                            occupancy--;
                        want.outcome = OUT_DROPPED;
                    end
                end
                REQ_DROP_ALL:
                begin
                    foreach (held_valid[i])
                        held_valid[i] = 1'b0;
                    occupancy    = 0;
                    recent_valid = 1'b0;
                    recent_x     = '0;
                    recent_z     = '0;
                    s            = 0;
                    want.outcome = OUT_ALL_DROPPED;
                end
                default:
                begin
                end
            endcase
            want.slot_index     = slot_idx_t'(s);
            want.resident_count = count_t'(occupancy);
            expected_results.push_back(want);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        // compare one result against the oldest prediction
        task check_response(column_result_t got);
            column_result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result, outcome", got.outcome, -1);
                return;
            end
            want = expected_results.pop_front();
            if (got.outcome !== want.outcome)
                report_mismatch("outcome", got.outcome, want.outcome);
            if (got.slot_index !== want.slot_index)
                report_mismatch("slot_index", got.slot_index, want.slot_index);
            if (got.evicted_x !== want.evicted_x)
                report_mismatch("evicted_x", got.evicted_x, want.evicted_x);
            if (got.evicted_z !== want.evicted_z)
                report_mismatch("evicted_z", got.evicted_z, want.evicted_z);
            if (got.resident_count !== want.resident_count)
                report_mismatch("resident_count", got.resident_count,
                                want.resident_count);
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dmct_req_if req_ch ();
    dmct_rsp_if rsp_ch ();

    direct_mapped_column_tag_store uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    tag_store_shadow shadow;

    // idle chances in percent, changed per phase by the main sequence
    int unsigned src_idle_pct  = 13;
    int unsigned sink_idle_pct = 87;
    int unsigned cycles        = 0;

    always #1 clk = ~clk;

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_direct_mapped_column_tag_store: done, errors");
            $finish;
        end
    end

    // present one request item and hold it until the block takes it;
    // valid is only ever lowered by an idle cycle or at the very end, so a
    // back-to-back item never sees valid dropped and raised in one step
    task automatic send_request(input req_type_t code, input coord_t x, input coord_t z);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= code;
        req_ch.col_x    <= x;
        req_ch.col_z    <= z;
        @(posedge clk);
        // ready seen here is the value the block had at this edge
        while (!req_ch.ready)
            @(posedge clk);
        shadow.note_request(code, x, z);
    endtask

    // result side: sample at the edge, check on a handshake, then pick
    // the ready level for the next cycle
    initial
    begin
        column_result_t seen;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                seen.outcome        = rsp_ch.outcome;
                seen.slot_index     = rsp_ch.slot_index;
                seen.evicted_x      = rsp_ch.evicted_x;
                seen.evicted_z      = rsp_ch.evicted_z;
                seen.resident_count = rsp_ch.resident_count;
                shadow.check_response(seen);
            end
            rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // main sequence
    initial
    begin
        coord_t      pool_x [POOL_SIZE];
        coord_t      pool_z [POOL_SIZE];
        coord_t      x;
        coord_t      z;
        coord_t      prev_x;
        coord_t      prev_z;
        bit [31:0]   high_x;
        bit [31:0]   high_z;
        req_type_t   code;
        int unsigned roll;
        int unsigned pick;

        shadow = new();
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_OBTAIN;
        req_ch.col_x    <= '0;
        req_ch.col_z    <= '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part; the block first sweeps its memory after reset
        send_request(REQ_OBTAIN, 0, 0);                       // fill an empty slot
        send_request(REQ_OBTAIN, 0, 0);                       // last-hit register
        send_request(REQ_OBTAIN, GRID, 0);                    // collides in slot 0
        send_request(REQ_OBTAIN, 0, 0);                       // evicts the collider
        send_request(REQ_OBTAIN, 32'sh7fffffff, 32'sh7fffffff); // top slot
        send_request(REQ_OBTAIN, 32'sh80000000, 32'sh80000000); // most negative
        send_request(REQ_OBTAIN, -1, -1);                     // evicts the maxima
        send_request(REQ_OBTAIN, 32'sh7fffffff, 32'sh7fffffff);
        send_request(REQ_OBTAIN, 32'sh80000000, 32'sh80000000); // slot hit, not last
        send_request(REQ_DROP, 5, 7);                         // drop from an empty slot
        send_request(REQ_DROP, 0, 0);                         // slot holds another column
        send_request(REQ_OBTAIN, 32'sh80000000, 32'sh80000000); // make it the last hit
        send_request(REQ_DROP, 32'sh80000000, 32'sh80000000); // drop clears last hit
        send_request(REQ_OBTAIN, 32'sh80000000, 32'sh80000000); // refill, no last hit
        send_request(REQ_DROP, 32'sh7fffffff, 32'sh7fffffff); // drop, last hit untouched
        send_request(REQ_UNUSED, 123, -456);                  // unused request code
        send_request(REQ_UNUSED, 32'sh7fffffff, 32'sh80000000);
        send_request(REQ_OBTAIN, 32'sh55555555, 32'shaaaaaaaa);
        send_request(REQ_OBTAIN, 32'shaaaaaaaa, 32'sh55555555);
        send_request(REQ_DROP_ALL, 32'sh12345678, -1);        // clears all, slot zero
        send_request(REQ_OBTAIN, 0, 0);                       // cleared last hit is zero
        send_request(REQ_DROP, 0, 0);
        send_request(REQ_DROP_ALL, 0, 0);                     // drop all on an empty store
        send_request(REQ_OBTAIN, 32'sh80000000, 32'sh80000000);

        // pool of columns packed into few slots, so that hits, collisions
        // and drops of resident columns are common; high bits are zero,
        // all ones or random
        foreach (pool_x[i])
        begin
            case ($urandom_range(3))
                0:
                begin
                    high_x = '0;
                    high_z = '0;
                end
                1:
                begin
                    high_x = '1;
                    high_z = '1;
                end
                default:
                begin
                    high_x = $urandom;
                    high_z = $urandom;
                end
            endcase
            pool_x[i] = (high_x & ~LOW_BITS_MASK) | $urandom_range(7);
            pool_z[i] = (high_z & ~LOW_BITS_MASK) | $urandom_range(3);
        end
        prev_x = pool_x[0];
        prev_z = pool_z[0];

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // idling phases: slow receiver, then slow sender, then none
            if (n == RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 87;
                sink_idle_pct = 13;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end

            // mostly obtains and drops, a few unused codes, rare drop-alls
            roll = $urandom_range(999);
            if (roll < 10)
                code = REQ_DROP_ALL;
            else if (roll < 40)
                code = REQ_UNUSED;
            else if (roll < 360)
                code = REQ_DROP;
            else
                code = REQ_OBTAIN;

            // coordinates: repeat the last column, take one from the pool,
            // or fully random for bit coverage
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                x = prev_x;
                z = prev_z;
            end
            else if (pick < 80)
            begin
                roll = $urandom_range(POOL_SIZE - 1);
                x = pool_x[roll];
                z = pool_z[roll];
            end
            else
            begin
                x = $urandom;
                z = $urandom;
            end

            send_request(code, x, z);
            prev_x = x;
            prev_z = z;
        end

        // last item was taken at this edge, nothing else drives valid here
        req_ch.valid <= 1'b0;

        while (shadow.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.expected_results.size() != 0)
            shadow.report_mismatch("missing results, count", 0,
                                   shadow.expected_results.size());

        if (shadow.errors == 0)
            $display("tb_direct_mapped_column_tag_store: done, clean");
        else
            $display("tb_direct_mapped_column_tag_store: done, errors");
        $finish;
    end

endmodule
